>>> sv/mmapt_pkg.sv
// ----------------------------------------------------------------------------
// mmapt_pkg
// Shared types and codes for the min-max-area triangulator.
// ----------------------------------------------------------------------------
package mmapt_pkg;

  localparam logic [1:0] ST_TRI   = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_NOSPL = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_INIT  = 3'd1,  // clear diagonal chains, start at length 2
    CMD_CHAIN = 3'd2,  // not acted on by the datapath
    CMD_WALK  = 3'd3   // walk the split table and emit every triangle
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;      // dp or walk finished
    logic root_ok;
  } dp_sts_t;

endpackage

>>> sv/mmapt_datapath.sv
// ----------------------------------------------------------------------------
// mmapt_datapath
// Vertex store, interval DP over chains, and preorder walk with a stack.
// ----------------------------------------------------------------------------
module mmapt_datapath
  import mmapt_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  logic [5:0]            wr_idx_i,
  input  logic [15:0]           x_i,
  input  logic [15:0]           y_i,
  input  logic [6:0]            n_i,
  input  dp_cmd_t               cmd_i,
  input  logic                  emit_stall_i,
  output dp_sts_t               sts_o,
  output logic                  emit_o,
  output logic [5:0]            ea_o,
  output logic [5:0]            eb_o,
  output logic [5:0]            ec_o,
  output logic                  elast_o
);

  localparam int AW = 2 * COORD_BITS + 4;
  localparam int CW = 36;

  logic signed [COORD_BITS-1:0] vx_mem [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] vy_mem [MAX_VERTICES];
  logic [CW-1:0] cost_mem  [4096];
  logic [6:0]    split_mem [4096];
  logic [11:0]   stk_mem   [64];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      vx_mem[wr_idx_i] <= x_i[COORD_BITS-1:0];
      vy_mem[wr_idx_i] <= y_i[COORD_BITS-1:0];
    end
  end

  // Sequencing registers
  localparam logic [3:0] P_IDLE = 4'd0, P_INIT = 4'd1, P_RD = 4'd2, P_RD2 = 4'd3,
                         P_MUL = 4'd4, P_CMP = 4'd5, P_WR = 4'd6, P_WPOP = 4'd7,
                         P_WRD = 4'd8, P_WEM = 4'd9, P_DONE = 4'd10;
  logic [3:0] ph_q;
  logic [5:0] len_q, s_q, m_q, bm_q;
  logic       found_q, root_q;
  logic [CW-1:0] best_q;
  logic [5:0] e_w;
  assign e_w = s_q + len_q;

  // read registers
  logic signed [COORD_BITS-1:0] xs_q, ys_q, xm_q, ym_q, xe_q, ye_q;
  logic [CW-1:0] cl_q, cr_q;
  logic [6:0]    sl_q, sr_q;
  logic signed [AW-1:0] p1_q, p2_q;
  logic [6:0] sp_q;
  logic [6:0] k_q;
  logic [11:0] top_q;
  logic [6:0]  sv_q;

  logic [11:0] ia_w, lidx_w, ridx_w;
  assign ia_w   = {s_q, e_w};
  assign lidx_w = {s_q, m_q};
  assign ridx_w = {m_q, e_w};

  logic signed [COORD_BITS:0] bx, by, cx, cy;
  assign bx = xm_q - xs_q;
  assign by = ym_q - ys_q;
  assign cx = xe_q - xs_q;
  assign cy = ye_q - ys_q;

  logic signed [AW-1:0] ar_w;
  assign ar_w = p1_q - p2_q;
  logic fin_l, fin_r;
  assign fin_l = (m_q == s_q + 6'd1) || sl_q[6];
  assign fin_r = (e_w == m_q + 6'd1) || sr_q[6];
  logic [CW-1:0] c_w;
  always_comb begin
    c_w = CW'(ar_w[AW-2:0]);
    if (cl_q > c_w) c_w = cl_q;
    if (cr_q > c_w) c_w = cr_q;
  end

  logic [5:0] nm1;
  assign nm1 = 6'(n_i - 7'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= P_IDLE;
      emit_o <= 1'b0;
      root_q <= 1'b0;
      sp_q <= '0;
      k_q <= '0;
      len_q <= '0;
      s_q <= '0;
      m_q <= '0;
      found_q <= 1'b0;
    end else begin
      if (emit_o && !emit_stall_i) emit_o <= 1'b0;
      case (ph_q)
        P_IDLE: begin
          if (cmd_i.cmd == CMD_INIT) begin
            ph_q <= P_INIT;
            s_q <= '0;
            len_q <= 6'd1;
          end else if (cmd_i.cmd == CMD_WALK) begin
            stk_mem[0] <= {6'd0, nm1};
            sp_q <= 7'd1;
            k_q <= '0;
            ph_q <= P_WPOP;
          end
        end
        P_INIT: begin
          cost_mem[ia_w] <= '0;
          split_mem[ia_w] <= '0;
          if (7'(e_w) + 7'd1 >= n_i) begin
            len_q <= 6'd2;
            s_q <= '0;
            m_q <= 6'd1;
            found_q <= 1'b0;
            ph_q <= (n_i > 7'd2) ? P_RD : P_DONE;
          end else s_q <= s_q + 6'd1;
        end
        P_RD: begin
          xs_q <= vx_mem[s_q]; ys_q <= vy_mem[s_q];
          xm_q <= vx_mem[m_q]; ym_q <= vy_mem[m_q];
          cl_q <= cost_mem[lidx_w]; sl_q <= split_mem[lidx_w];
          ph_q <= P_RD2;
        end
        P_RD2: begin
          xe_q <= vx_mem[e_w]; ye_q <= vy_mem[e_w];
          cr_q <= cost_mem[ridx_w]; sr_q <= split_mem[ridx_w];
          ph_q <= P_MUL;
        end
        P_MUL: begin
          p1_q <= AW'(bx * cy);
          p2_q <= AW'(by * cx);
          ph_q <= P_CMP;
        end
        P_CMP: begin
          if (!ar_w[AW-1] && ar_w != '0 && fin_l && fin_r &&
              (!found_q || c_w < best_q)) begin
            found_q <= 1'b1;
            best_q <= c_w;
            bm_q <= m_q;
          end
          if (m_q + 6'd1 == e_w) ph_q <= P_WR;
          else begin
            m_q <= m_q + 6'd1;
            ph_q <= P_RD;
          end
        end
        P_WR: begin
          cost_mem[ia_w] <= found_q ? best_q : '0;
          split_mem[ia_w] <= found_q ? {1'b1, bm_q} : 7'd0;
          found_q <= 1'b0;
          if (7'(e_w) + 7'd1 >= n_i) begin
            if (7'(len_q) + 7'd1 >= n_i) begin
              root_q <= found_q;
              ph_q <= P_DONE;
            end else begin
              len_q <= len_q + 6'd1;
              s_q <= '0;
              m_q <= 6'd1;
              ph_q <= P_RD;
            end
          end else begin
            s_q <= s_q + 6'd1;
            m_q <= s_q + 6'd2;
            ph_q <= P_RD;
          end
        end
        P_WPOP: begin
          if (!emit_o) begin
            if (sp_q == '0) ph_q <= P_DONE;
            else begin
              top_q <= stk_mem[6'(sp_q - 7'd1)];
              sp_q <= sp_q - 7'd1;
              ph_q <= P_WRD;
            end
          end
        end
        P_WRD: begin
          sv_q <= split_mem[top_q];
          ph_q <= P_WEM;
        end
        P_WEM: begin
          ph_q <= P_WPOP;
          if (sv_q[6] && k_q < 7'(MAX_VERTICES - 2)) begin
            logic [6:0] spn;
            spn = sp_q;
            emit_o <= 1'b1;
            ea_o <= top_q[11:6];
            eb_o <= sv_q[5:0];
            ec_o <= top_q[5:0];
            k_q <= k_q + 7'd1;
            // last triangle is always the (n-2)th
            elast_o <= (k_q + 7'd1 == 7'(n_i - 7'd2));
            if (top_q[5:0] > sv_q[5:0] + 6'd1 && spn < 7'(MAX_VERTICES)) begin
              stk_mem[spn[5:0]] <= {sv_q[5:0], top_q[5:0]};
              spn = spn + 7'd1;
            end
            if (sv_q[5:0] > top_q[11:6] + 6'd1 && spn < 7'(MAX_VERTICES)) begin
              stk_mem[spn[5:0]] <= {top_q[11:6], sv_q[5:0]};
              spn = spn + 7'd1;
            end
            sp_q <= spn;
          end
        end
        P_DONE: if (!emit_o) ph_q <= P_IDLE;
        default: ph_q <= P_IDLE;
      endcase
    end
  end

  assign sts_o.busy    = (ph_q != P_IDLE);
  assign sts_o.done    = (ph_q == P_DONE) && !emit_o;
  assign sts_o.root_ok = root_q;

  ap_emit_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(emit_o) |-> $past(ph_q) == P_WEM) else $error("emit outside walk");
  ap_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= 7'(MAX_VERTICES)) else $error("stack overrun");
  ap_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= 7'(MAX_VERTICES - 2)) else $error("too many triangles");

endmodule

>>> sv/mmapt_ctrl.sv
// ----------------------------------------------------------------------------
// mmapt_ctrl
// Load control, status results and sequencing of the DP and the walk.
// ----------------------------------------------------------------------------
module mmapt_ctrl
  import mmapt_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       last_i,
  output logic       in_stall_o,
  output logic       wr_o,
  output logic [5:0] wr_idx_o,
  output logic [6:0] n_o,
  output dp_cmd_t    cmd_o,
  input  dp_sts_t    sts_i,
  output logic       st_valid_o,
  output logic [1:0] st_code_o,
  input  logic       st_take_i
);

  localparam logic [2:0] S_LOAD = 3'd0, S_DP = 3'd1, S_CHK = 3'd2, S_WALK = 3'd3,
                         S_STAT = 3'd4, S_WAIT = 3'd5;
  logic [2:0] state_q;
  logic [6:0] cnt_q, n_q;
  logic       ovf_q;
  logic [1:0] code_q;

  logic acc;
  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_LOAD);
  assign wr_o = acc && (cnt_q < 7'(MAX_VERTICES));
  assign wr_idx_o = cnt_q[5:0];
  assign n_o = n_q;
  assign st_valid_o = (state_q == S_STAT);
  assign st_code_o = code_q;

  logic [6:0] n_w;
  assign n_w = wr_o ? cnt_q + 7'd1 : cnt_q;

  always_comb begin
    cmd_o.cmd = CMD_NONE;
    if (state_q == S_DP && !sts_i.busy) cmd_o.cmd = CMD_INIT;
    if (state_q == S_CHK && !sts_i.busy && sts_i.root_ok) cmd_o.cmd = CMD_WALK;
  end

  logic started_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      n_q <= '0;
      code_q <= ST_TRI;
      started_q <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: if (acc) begin
          if (last_i) begin
            n_q <= n_w;
            cnt_q <= '0;
            ovf_q <= 1'b0;
            if (ovf_q || !wr_o) begin
              code_q <= ST_OVF; state_q <= S_STAT;
            end else if (n_w < 7'd3) begin
              code_q <= ST_SHORT; state_q <= S_STAT;
            end else state_q <= S_DP;
          end else begin
            cnt_q <= n_w;
            if (!wr_o) ovf_q <= 1'b1;
          end
        end
        S_DP: begin
          if (cmd_o.cmd == CMD_INIT) started_q <= 1'b1;
          if (started_q && sts_i.done) begin
            started_q <= 1'b0;
            state_q <= S_CHK;
          end
        end
        S_CHK: if (!sts_i.busy) begin
          if (sts_i.root_ok) state_q <= S_WALK;
          else begin
            code_q <= ST_NOSPL; state_q <= S_STAT;
          end
        end
        S_WALK: begin
          if (sts_i.busy) started_q <= 1'b1;
          if (started_q && sts_i.done) begin
            started_q <= 1'b0;
            state_q <= S_WAIT;
          end
        end
        S_WAIT: if (!sts_i.busy) state_q <= S_LOAD;
        S_STAT: if (st_take_i) state_q <= S_LOAD;
        default: state_q <= S_LOAD;
      endcase
    end
  end

  ap_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.busy |-> !acc) else $error("word taken while busy");
  ap_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(MAX_VERTICES)) else $error("count overrun");
  ap_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_valid_o |-> !sts_i.busy) else $error("status during dp");

endmodule

>>> sv/minmax_area_polygon_triangulator.sv
// ----------------------------------------------------------------------------
// minmax_area_polygon_triangulator
// Loads a convex polygon and emits a min-max-area triangulation.
// ----------------------------------------------------------------------------
// channel | dir | handshake               | payload
// in      | in  | in_valid_i/in_stall_o   | x_i y_i last_i
// out     | out | out_valid_o/out_stall_i | corner_a/b/c_o status_o final_res_o
// Vertices load one word per cycle while not stalled. After last, the DP
// evaluates each split of every chain in turn (two memory reads,
// multiply, compare) and then writes the chain's cost and split.
// The walk then emits each popped chain's triangle from the split table.
// Reset is asynchronous; memories need no clearing. Input stalls during work.
// ----------------------------------------------------------------------------
module minmax_area_polygon_triangulator
  import mmapt_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] x_i,
  input  logic [15:0] y_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  corner_a_o,
  output logic [5:0]  corner_b_o,
  output logic [5:0]  corner_c_o,
  output logic [1:0]  status_o,
  output logic        final_res_o
);

  logic wr; logic [5:0] wr_idx; logic [6:0] n;
  dp_cmd_t cmd; dp_sts_t sts;
  logic st_valid; logic [1:0] st_code;
  logic emit, elast; logic [5:0] ea, eb, ec;

  mmapt_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .last_i, .in_stall_o,
    .wr_o(wr), .wr_idx_o(wr_idx), .n_o(n), .cmd_o(cmd), .sts_i(sts),
    .st_valid_o(st_valid), .st_code_o(st_code), .st_take_i(!out_stall_i)
  );

  mmapt_datapath #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk_i, .rst_ni, .wr_i(wr), .wr_idx_i(wr_idx), .x_i, .y_i, .n_i(n),
    .cmd_i(cmd), .emit_stall_i(out_stall_i), .sts_o(sts),
    .emit_o(emit), .ea_o(ea), .eb_o(eb), .ec_o(ec), .elast_o(elast)
  );

  assign out_valid_o = emit || st_valid;
  assign corner_a_o  = emit ? ea : 6'd0;
  assign corner_b_o  = emit ? eb : 6'd0;
  assign corner_c_o  = emit ? ec : 6'd0;
  assign status_o    = emit ? ST_TRI : st_code;
  assign final_res_o = emit ? elast : 1'b1;

endmodule

>>> bench/minmax_area_polygon_triangulator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// minmax_area_polygon_triangulator_tb
// Feeds polygons as vertex words: a directed table, then random polygons.
// Most are convex, some are noise, short or oversized. Each emitted triangle
// or status word is checked against a local min-max-area triangulation.
// ----------------------------------------------------------------------------
module minmax_area_polygon_triangulator_tb;
  import mmapt_pkg::*;

  localparam int NV = 64;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    bit          typed;   // expected status written in the table
    logic [1:0]  st;
  } vtx_word_t;

  typedef struct packed {
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] c;
    logic [1:0] st;
    logic       fin;
  } tri_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] x_i = '0;
  logic [15:0] y_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [5:0]  corner_a_o, corner_b_o, corner_c_o;
  logic [1:0]  status_o;
  logic        final_res_o;

  minmax_area_polygon_triangulator dut (.*);

  always #1 clk_i = ~clk_i;

  vtx_word_t vtx_q[$];
  tri_word_t tri_q[$];
  int        errors = 0;
  int        n_words = 0;
  int        n_polys = 0;
  int        n_cyc = 0;
  bit        stim_done = 0;

  // local copy of the block state
  longint     px[NV];
  longint     py[NV];
  int         pcnt = 0;
  bit         povf = 0;
  logic [35:0] pcost[NV][NV];
  bit          pok[NV][NV];
  logic [5:0]  pspl[NV][NV];

  function automatic longint area2(int a, int b, int c);
    return (px[b] - px[a]) * (py[c] - py[a]) - (py[b] - py[a]) * (px[c] - px[a]);
  endfunction

  function automatic bit chain_ok(int s, int e);
    return (e == s + 1) || pok[s][e];
  endfunction

  function automatic tri_word_t tw(logic [5:0] a, logic [5:0] b, logic [5:0] c,
                                   logic [1:0] st, logic fin);
    tri_word_t r;
    r.a = a;
    r.b = b;
    r.c = c;
    r.st = st;
    r.fin = fin;
    return r;
  endfunction

  task automatic triangulate(input logic [15:0] x, input logic [15:0] y,
                             input logic last, output tri_word_t res[$]);
    int n, sp, k, s, e, m;
    bit found;
    longint ar;
    logic [35:0] best, c;
    int bm;
    int stk_s[NV];
    int stk_e[NV];
    res = {};
    if (pcnt < NV) begin
      px[pcnt] = longint'($signed(x));
      py[pcnt] = longint'($signed(y));
      pcnt++;
    end else begin
      povf = 1;
    end
    if (!last) return;
    n = pcnt;
    pcnt = 0;
    if (povf) begin
      povf = 0;
      res = {res, tw(6'd0, 6'd0, 6'd0, ST_OVF, 1'b1)};
      return;
    end
    if (n < 3) begin
      res = {res, tw(6'd0, 6'd0, 6'd0, ST_SHORT, 1'b1)};
      return;
    end
    for (s = 0; s + 1 < n; s++) begin
      pcost[s][s+1] = '0;
      pok[s][s+1] = 0;
    end
    for (int len = 2; len < n; len++) begin
      for (s = 0; s + len < n; s++) begin
        e = s + len;
        found = 0;
        best = '0;
        bm = 0;
        for (m = s + 1; m < e; m++) begin
          ar = area2(s, m, e);
          if (ar <= 0 || !chain_ok(s, m) || !chain_ok(m, e)) continue;
          c = ar[35:0];
          if (pcost[s][m] > c) c = pcost[s][m];
          if (pcost[m][e] > c) c = pcost[m][e];
          if (!found || c < best) begin
            found = 1;
            best = c;
            bm = m;
          end
        end
        pcost[s][e] = found ? best : '0;
        pok[s][e] = found;
        pspl[s][e] = bm[5:0];
      end
    end
    if (!pok[0][n-1]) begin
      res = {res, tw(6'd0, 6'd0, 6'd0, ST_NOSPL, 1'b1)};
      return;
    end
    sp = 1;
    stk_s[0] = 0;
    stk_e[0] = n - 1;
    k = 0;
    while (sp > 0) begin
      sp--;
      s = stk_s[sp];
      e = stk_e[sp];
      if (!pok[s][e] || k >= NV - 2) continue;
      m = pspl[s][e];
      res = {res, tw(s[5:0], m[5:0], e[5:0], ST_TRI, 1'b0)};
      k++;
      if (e > m + 1 && sp < NV) begin
        stk_s[sp] = m; stk_e[sp] = e; sp++;
      end
      if (m > s + 1 && sp < NV) begin
        stk_s[sp] = s; stk_e[sp] = m; sp++;
      end
    end
    res[k-1].fin = 1'b1;
  endtask

  function automatic vtx_word_t mk(longint x, longint y, bit last,
                                   bit typed = 0, logic [1:0] st = ST_TRI);
    vtx_word_t w;
    w.x = x[15:0];
    w.y = y[15:0];
    w.last = last;
    w.typed = typed;
    w.st = st;
    return w;
  endfunction

  // n vertices on a parabola, ordered so every split is counter-clockwise (clockwise if flip)
  task automatic add_convex(int n, bit flip);
    longint x0, stp, xx, yy, off;
    stp = $urandom_range(65000 / n, 1);
    x0 = -32768 + $urandom_range(65535 - stp * (n - 1), 0);
    off = $urandom_range(32767, 0);
    for (int i = 0; i < n; i++) begin
      xx = x0 + i * stp;
      yy = ((xx * xx) >>> 15) - off;
      if (flip) yy = -yy;
      vtx_q = {vtx_q, mk(xx, yy, i == n - 1)};
    end
  endtask

  task automatic add_noise(int n);
    for (int i = 0; i < n; i++)
      vtx_q = {vtx_q, mk($urandom, $urandom, i == n - 1)};
  endtask

  // idling: about 12 in a hundred, none inside the calm window
  function automatic bit idle_now();
    if (n_cyc > 2000 && n_cyc < 5000) return 0;
    return $urandom_range(99, 0) < 12;
  endfunction

  initial begin
    // directed table
    vtx_q = {vtx_q, mk(0, 0, 1, 1, ST_SHORT)};
    vtx_q = {vtx_q, mk(32767, -32768, 0)};
    vtx_q = {vtx_q, mk(-32768, 32767, 1, 1, ST_SHORT)};
    vtx_q = {vtx_q, mk(0, 0, 0)};
    vtx_q = {vtx_q, mk(1, 0, 0)};
    vtx_q = {vtx_q, mk(0, 1, 1)};
    vtx_q = {vtx_q, mk(0, 0, 0)};       // clockwise
    vtx_q = {vtx_q, mk(0, 1, 0)};
    vtx_q = {vtx_q, mk(1, 0, 1, 1, ST_NOSPL)};
    vtx_q = {vtx_q, mk(-5, -5, 0)};     // collinear
    vtx_q = {vtx_q, mk(0, 0, 0)};
    vtx_q = {vtx_q, mk(5, 5, 1, 1, ST_NOSPL)};
    vtx_q = {vtx_q, mk(-32768, -32768, 0)};
    vtx_q = {vtx_q, mk(32767, -32768, 0)};
    vtx_q = {vtx_q, mk(32767, 32767, 1)};
    vtx_q = {vtx_q, mk(-32768, -32768, 0)};  // square
    vtx_q = {vtx_q, mk(32767, -32768, 0)};
    vtx_q = {vtx_q, mk(32767, 32767, 0)};
    vtx_q = {vtx_q, mk(-32768, 32767, 1)};
    vtx_q = {vtx_q, mk(-1, -1, 0)};
    vtx_q = {vtx_q, mk(0, -1, 0)};
    vtx_q = {vtx_q, mk(0, 0, 0)};
    vtx_q = {vtx_q, mk(-1, 0, 0)};
    vtx_q = {vtx_q, mk(-1, 0, 1)};      // repeated vertex
    // random polygons
    add_convex(NV, 0);
    add_noise(NV + 2);
    while (vtx_q.size() < 270) begin
      case ($urandom_range(9, 0))
        0:       add_noise($urandom_range(2, 1));
        1, 2:    add_noise($urandom_range(8, 3));
        3:       add_convex($urandom_range(8, 3), 1);
        default: add_convex($urandom_range(10, 3), 0);
      endcase
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  logic [1:0] typed_st = ST_TRI;
  bit         typed_on = 0;

  // vertex driver
  always @(posedge clk_i) begin
    n_cyc <= n_cyc + 1;
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (vtx_q.size() == 0) begin
        in_valid_i <= 1'b0;
        stim_done <= 1;
      end else if (idle_now()) begin
        in_valid_i <= 1'b0;
      end else begin
        vtx_word_t w;
        w = vtx_q.pop_front();
        in_valid_i <= 1'b1;
        x_i <= w.x;
        y_i <= w.y;
        last_i <= w.last;
        typed_st <= w.st;
        typed_on <= w.typed;
      end
    end
    out_stall_i <= idle_now();
  end

  // accepted words: predict and check
  always @(posedge clk_i) begin
    tri_word_t res[$];
    tri_word_t got, want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      n_words++;
      triangulate(x_i, y_i, last_i, res);
      if (last_i) n_polys++;
      if (last_i && typed_on) res = '{'{6'd0, 6'd0, 6'd0, typed_st, 1'b1}};
      foreach (res[i]) tri_q = {tri_q, res[i]};
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{corner_a_o, corner_b_o, corner_c_o, status_o, final_res_o};
      if (tri_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, got);
      end else begin
        want = tri_q.pop_front();
        if (got.a !== want.a)
          $display("%0t: corner_a exp %0d got %0d", $time, want.a, got.a);
        if (got.b !== want.b)
          $display("%0t: corner_b exp %0d got %0d", $time, want.b, got.b);
        if (got.c !== want.c)
          $display("%0t: corner_c exp %0d got %0d", $time, want.c, got.c);
        if (got.st !== want.st)
          $display("%0t: status exp %0d got %0d", $time, want.st, got.st);
        if (got.fin !== want.fin)
          $display("%0t: final_res exp %0d got %0d", $time, want.fin, got.fin);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (tri_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("%0d vertex words, %0d polygons: convex, noisy, short, full and overflow",
             n_words, n_polys);
    if (errors == 0) begin
      $display("minmax_area_polygon_triangulator_tb: clean");
    end else begin
      $display("minmax_area_polygon_triangulator_tb: errors");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("timeout, %0d words still expected", tri_q.size());
    $display("minmax_area_polygon_triangulator_tb: errors");
    $finish;
  end

endmodule

>>> minmax_area_polygon_triangulator.f
sv/mmapt_pkg.sv
sv/mmapt_datapath.sv
sv/mmapt_ctrl.sv
sv/minmax_area_polygon_triangulator.sv
bench/minmax_area_polygon_triangulator_tb.sv
